// ===== hdl/gpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared types and constants of the grid projection accumulator.
// ----------------------------------------------------------------------------
package gpa_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int SUM_BITS_DEF  = 48;

    localparam int ACTION_W    = 2;
    localparam int COORD_W     = 8;
    localparam int SHIFT_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int OUT_SUM_W   = 48;
    localparam int COUNT_W     = 16;
    localparam int FINE_W      = 9;
    localparam int MAX_SHIFT   = 8;
    localparam int SPAN_W      = COORD_W + MAX_SHIFT;
    localparam int WGT_W       = VALUE_W + MAX_SHIFT;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FINE_W-1:0] SIDE_RESET = 9'd256;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 1'b1;

    typedef enum logic [1:0] {
        K_ADD,
        K_READ,
        K_READ_ZERO,
        K_CLEAR
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_RD,
        S_WR,
        S_RDOUT
    } t_state;

    typedef struct packed {
        t_kind                      kind;
        logic [FINE_W-1:0]          fine_row;
        logic [FINE_W-1:0]          fine_col;
        logic [SHIFT_W-1:0]         shift;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic              combine_mode;
        logic [FINE_W-1:0] side;
    } t_cfg;

endpackage
`default_nettype wire

// ===== hdl/gpa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_front
// Accepts requests, maps cells to fine coordinates, drops requests that
// change nothing and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module gpa_front (
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [gpa_pkg::ACTION_W-1:0]         i_action,
    input  wire  [gpa_pkg::COORD_W-1:0]          i_row,
    input  wire  [gpa_pkg::COORD_W-1:0]          i_col,
    input  wire  [gpa_pkg::SHIFT_W-1:0]          i_ratio_shift,
    input  wire  signed [gpa_pkg::VALUE_W-1:0]   i_cell_value,
    input  wire                                  i_refined,
    input  gpa_pkg::t_cfg                        i_cfg,
    input  wire                                  i_q_full,
    input  wire                                  i_init_busy,
    output logic                                 o_push,
    output gpa_pkg::t_cmd                        o_cmd
);

    logic [gpa_pkg::SPAN_W-1:0] r0;
    logic [gpa_pkg::SPAN_W-1:0] c0;
    logic [gpa_pkg::SPAN_W-1:0] side_ext;
    logic                       in_add;
    logic                       in_read;
    logic                       keep;

    always_comb begin
        r0       = gpa_pkg::SPAN_W'(i_row) << i_ratio_shift;
        c0       = gpa_pkg::SPAN_W'(i_col) << i_ratio_shift;
        side_ext = gpa_pkg::SPAN_W'(i_cfg.side);
        in_add   = !i_refined
                && (i_ratio_shift <= gpa_pkg::SHIFT_W'(gpa_pkg::MAX_SHIFT))
                && (r0 < side_ext) && (c0 < side_ext);
        in_read  = (gpa_pkg::FINE_W'(i_row) < i_cfg.side)
                && (gpa_pkg::FINE_W'(i_col) < i_cfg.side);

        o_cmd.kind     = gpa_pkg::K_ADD;
        o_cmd.fine_row = gpa_pkg::FINE_W'(r0);
        o_cmd.fine_col = gpa_pkg::FINE_W'(c0);
        o_cmd.shift    = i_ratio_shift;
        o_cmd.value    = i_cell_value;
        keep           = 1'b0;

        unique case (i_action)
            gpa_pkg::ACT_ADD: begin
                keep = in_add;
            end
            gpa_pkg::ACT_READ: begin
                o_cmd.kind     = in_read ? gpa_pkg::K_READ : gpa_pkg::K_READ_ZERO;
                o_cmd.fine_row = gpa_pkg::FINE_W'(i_row);
                o_cmd.fine_col = gpa_pkg::FINE_W'(i_col);
                keep           = 1'b1;
            end
            gpa_pkg::ACT_CLEAR: begin
                o_cmd.kind = gpa_pkg::K_CLEAR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full && !i_init_busy;
    assign o_push  = i_valid && o_ready && keep;

endmodule
`default_nettype wire

// ===== hdl/gpa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gpa_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  gpa_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output gpa_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = (gpa_pkg::QUEUE_DEPTH > 1) ? $clog2(gpa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gpa_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gpa_pkg::QUEUE_DEPTH - 1);

    gpa_pkg::t_cmd     r_q [gpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(gpa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gpa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_back
// Executes commands against the entry store: read-modify-write sweep over
// the covered square, entry reads, and clearing passes.
// ----------------------------------------------------------------------------
module gpa_back #(
    parameter int GRID_SIDE = gpa_pkg::GRID_SIDE_DEF,
    parameter int SUM_BITS  = gpa_pkg::SUM_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  gpa_pkg::t_cfg                        i_cfg,
    input  wire                                  i_q_valid,
    input  gpa_pkg::t_cmd                        i_q_cmd,
    output logic                                 o_q_pop,
    output logic                                 o_init_busy,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [gpa_pkg::OUT_SUM_W-1:0] o_entry_sum,
    output logic [gpa_pkg::COUNT_W-1:0]          o_entry_count
);

    localparam int ENTRIES = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int WORD_W  = SUM_BITS + gpa_pkg::COUNT_W;
    localparam int WIDE_W  = ((SUM_BITS > gpa_pkg::WGT_W) ? SUM_BITS : gpa_pkg::WGT_W) + 1;
    localparam int RD_W    = (SUM_BITS > gpa_pkg::OUT_SUM_W) ? SUM_BITS : gpa_pkg::OUT_SUM_W;
    localparam int FW      = gpa_pkg::FINE_W;
    localparam int CW      = gpa_pkg::COUNT_W;
    localparam int OW      = gpa_pkg::OUT_SUM_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
    localparam logic signed [WIDE_W-1:0] SUM_HI =
        {{(WIDE_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SUM_LO =
        {{(WIDE_W-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};
    localparam logic signed [RD_W-1:0] OUT_HI =
        {{(RD_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [RD_W-1:0] OUT_LO =
        {{(RD_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic [WORD_W-1:0] r_mem [ENTRIES];
    logic [WORD_W-1:0] r_rdata;

    gpa_pkg::t_state                    r_state, n_state;
    logic                               r_init, n_init;
    logic [ADDR_W-1:0]                  r_clr, n_clr;
    logic [ADDR_W-1:0]                  r_row_base, n_row_base;
    logic [FW-1:0]                      r_fr, n_fr;
    logic [FW-1:0]                      r_fc, n_fc;
    logic [FW-1:0]                      r_c0, n_c0;
    logic [7:0]                         r_a, n_a;
    logic [7:0]                         r_b, n_b;
    logic [gpa_pkg::SHIFT_W-1:0]        r_shift, n_shift;
    logic signed [gpa_pkg::VALUE_W-1:0] r_value, n_value;
    logic                               r_zero, n_zero;
    logic                               r_is_read, n_is_read;
    logic                               r_ovalid, n_ovalid;
    logic signed [OW-1:0]               r_osum, n_osum;
    logic [CW-1:0]                      r_ocount, n_ocount;

    logic [2*FW-1:0]             prod;
    logic [ADDR_W-1:0]           idx;
    logic [ADDR_W-1:0]           mem_wa;
    logic                        mem_we;
    logic [WORD_W-1:0]           mem_wd;
    logic signed [SUM_BITS-1:0]  s_old;
    logic [CW-1:0]               cnt_old;
    logic signed [gpa_pkg::WGT_W-1:0] wgt;
    logic signed [WIDE_W-1:0]    exact;
    logic signed [SUM_BITS-1:0]  val_ext;
    logic signed [SUM_BITS-1:0]  new_sum;
    logic [CW-1:0]               new_cnt;
    logic signed [RD_W-1:0]      rd_ext;
    logic signed [RD_W-1:0]      rd_sat;
    logic [7:0]                  mask;
    logic                        more_col;
    logic                        more_row;

    assign prod    = (2*FW)'(r_fr) * (2*FW)'(i_cfg.side);
    assign idx     = r_row_base + ADDR_W'(r_fc);
    assign mem_wa  = (r_state == gpa_pkg::S_CLEAR) ? r_clr : idx;
    assign s_old   = r_rdata[CW +: SUM_BITS];
    assign cnt_old = r_rdata[CW-1:0];
    assign mask    = 8'((9'd1 << r_shift) - 9'd1);

    always_comb begin
        wgt     = gpa_pkg::WGT_W'(r_value) <<< r_shift;
        exact   = WIDE_W'(s_old) + WIDE_W'(wgt);
        val_ext = SUM_BITS'(r_value);
        if (i_cfg.combine_mode) begin
            new_sum = (val_ext > s_old) ? val_ext : s_old;
        end else if (exact > SUM_HI) begin
            new_sum = SUM_BITS'(SUM_HI);
        end else if (exact < SUM_LO) begin
            new_sum = SUM_BITS'(SUM_LO);
        end else begin
            new_sum = SUM_BITS'(exact);
        end
        new_cnt = (&cnt_old) ? cnt_old : cnt_old + 1'b1;

        rd_ext = RD_W'(s_old);
        if (rd_ext > OUT_HI) begin
            rd_sat = OUT_HI;
        end else if (rd_ext < OUT_LO) begin
            rd_sat = OUT_LO;
        end else begin
            rd_sat = rd_ext;
        end

        more_col = (r_b != mask) && ((10'(r_fc) + 10'd1) < 10'(i_cfg.side));
        more_row = (r_a != mask) && ((10'(r_fr) + 10'd1) < 10'(i_cfg.side));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[idx];
    end

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_clr      = r_clr;
        n_row_base = r_row_base;
        n_fr       = r_fr;
        n_fc       = r_fc;
        n_c0       = r_c0;
        n_a        = r_a;
        n_b        = r_b;
        n_shift    = r_shift;
        n_value    = r_value;
        n_zero     = r_zero;
        n_is_read  = r_is_read;
        n_ovalid   = r_ovalid;
        n_osum     = r_osum;
        n_ocount   = r_ocount;
        mem_we     = 1'b0;
        mem_wd     = '0;
        o_q_pop    = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            gpa_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_clr   = '0;
                    n_init  = 1'b0;
                    n_state = gpa_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            gpa_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_fr      = i_q_cmd.fine_row;
                    n_fc      = i_q_cmd.fine_col;
                    n_c0      = i_q_cmd.fine_col;
                    n_shift   = i_q_cmd.shift;
                    n_value   = i_q_cmd.value;
                    n_a       = '0;
                    n_b       = '0;
                    n_zero    = (i_q_cmd.kind == gpa_pkg::K_READ_ZERO);
                    n_is_read = (i_q_cmd.kind == gpa_pkg::K_READ);
                    unique case (i_q_cmd.kind)
                        gpa_pkg::K_ADD:       n_state = gpa_pkg::S_MUL;
                        gpa_pkg::K_READ:      n_state = gpa_pkg::S_MUL;
                        gpa_pkg::K_READ_ZERO: n_state = gpa_pkg::S_RDOUT;
                        gpa_pkg::K_CLEAR: begin
                            n_clr   = '0;
                            n_state = gpa_pkg::S_CLEAR;
                        end
                        default:              n_state = gpa_pkg::S_IDLE;
                    endcase
                end
            end
            gpa_pkg::S_MUL: begin
                n_row_base = ADDR_W'(prod);
                n_state    = gpa_pkg::S_RD;
            end
            gpa_pkg::S_RD: begin
                n_state = r_is_read ? gpa_pkg::S_RDOUT : gpa_pkg::S_WR;
            end
            gpa_pkg::S_WR: begin
                mem_we = 1'b1;
                mem_wd = {new_sum, new_cnt};
                if (more_col) begin
                    n_b     = r_b + 1'b1;
                    n_fc    = r_fc + 1'b1;
                    n_state = gpa_pkg::S_RD;
                end else if (more_row) begin
                    n_a        = r_a + 1'b1;
                    n_fr       = r_fr + 1'b1;
                    n_b        = '0;
                    n_fc       = r_c0;
                    n_row_base = r_row_base + ADDR_W'(i_cfg.side);
                    n_state    = gpa_pkg::S_RD;
                end else begin
                    n_state = gpa_pkg::S_IDLE;
                end
            end
            gpa_pkg::S_RDOUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_osum   = r_zero ? '0 : OW'(rd_sat);
                    n_ocount = r_zero ? '0 : cnt_old;
                    n_state  = gpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gpa_pkg::S_CLEAR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_base <= n_row_base;
        r_fr       <= n_fr;
        r_fc       <= n_fc;
        r_c0       <= n_c0;
        r_a        <= n_a;
        r_b        <= n_b;
        r_shift    <= n_shift;
        r_value    <= n_value;
        r_zero     <= n_zero;
        r_is_read  <= n_is_read;
        r_osum     <= n_osum;
        r_ocount   <= n_ocount;
    end

    assign o_init_busy   = r_init;
    assign o_valid       = r_ovalid;
    assign o_entry_sum   = r_osum;
    assign o_entry_count = r_ocount;

`ifndef ASSERT_OFF
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == gpa_pkg::S_WR || r_state == gpa_pkg::S_CLEAR))
        else $error("store written outside write or clear state");

    a_wr_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gpa_pkg::S_WR) |-> (r_fr < i_cfg.side && r_fc < i_cfg.side))
        else $error("write to entry outside the grid side");

    a_rdout_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gpa_pkg::S_RDOUT && (!r_ovalid || i_ready)) |=>
            (r_ovalid && r_state == gpa_pkg::S_IDLE))
        else $error("read result not loaded");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == gpa_pkg::S_CLEAR && !o_q_pop))
        else $error("command taken during initial clear");
`endif

endmodule
`default_nettype wire

// ===== hdl/grid_projection_accumulator.sv =====
// Read request: the back end passes through its multiply, read and result states; outside
// the side it goes straight to the result state. Add request: after the multiply state,
// one read and one write of the entry store per fine entry covered inside the side.
// Clear request: one entry per cycle, over all GRID_SIDE * GRID_SIDE entries of the store.
// Reset: synchronous; a clearing pass over all GRID_SIDE * GRID_SIDE entries
// (65536 at the default) follows, with o_ready low until it ends.
`default_nettype none
// ----------------------------------------------------------------------------
// grid_projection_accumulator
// Projects multi-level grid cells onto a square image of fine entries,
// keeping a saturating sum or maximum and a contribution count per entry.
// ----------------------------------------------------------------------------
module grid_projection_accumulator #(
    parameter int GRID_SIDE = gpa_pkg::GRID_SIDE_DEF,
    parameter int SUM_BITS  = gpa_pkg::SUM_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [gpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [gpa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [gpa_pkg::ACTION_W-1:0]         i_action,
    input  wire  [gpa_pkg::COORD_W-1:0]          i_row,
    input  wire  [gpa_pkg::COORD_W-1:0]          i_col,
    input  wire  [gpa_pkg::SHIFT_W-1:0]          i_ratio_shift,
    input  wire  signed [gpa_pkg::VALUE_W-1:0]   i_cell_value,
    input  wire                                  i_refined,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [gpa_pkg::OUT_SUM_W-1:0] o_entry_sum,
    output logic [gpa_pkg::COUNT_W-1:0]          o_entry_count
);

    localparam int SIDE_CMP_W = 14;

    logic                        r_combine_mode;
    logic [gpa_pkg::FINE_W-1:0]  r_grid_side;
    gpa_pkg::t_cfg               cfg;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    gpa_pkg::t_cmd               push_cmd;
    gpa_pkg::t_cmd               pop_cmd;
    logic                        init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combine_mode <= 1'b0;
            r_grid_side    <= gpa_pkg::SIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gpa_pkg::CFG_MODE: r_combine_mode <= i_cfg_data[0];
                gpa_pkg::CFG_SIDE: r_grid_side    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.combine_mode = r_combine_mode;
        if (SIDE_CMP_W'(r_grid_side) > SIDE_CMP_W'(GRID_SIDE)) begin
            cfg.side = gpa_pkg::FINE_W'(GRID_SIDE);
        end else begin
            cfg.side = r_grid_side;
        end
    end

    gpa_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_ratio_shift (i_ratio_shift),
        .i_cell_value  (i_cell_value),
        .i_refined     (i_refined),
        .i_cfg         (cfg),
        .i_q_full      (q_full),
        .i_init_busy   (init_busy),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    gpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    gpa_back #(
        .GRID_SIDE (GRID_SIDE),
        .SUM_BITS  (SUM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_q_cmd       (pop_cmd),
        .o_q_pop       (q_pop),
        .o_init_busy   (init_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_entry_sum   (o_entry_sum),
        .o_entry_count (o_entry_count)
    );

endmodule
`default_nettype wire
